/* rtl/dpt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the director transport block.
// Used by dpt_norm and director_parallel_transport_unit; depends on nothing else.
package dpt_pkg;

  // Number format: signed, WB bits, FRAC fractional bits; word width limited to 32
  localparam int WORD_BITS = 32;
  localparam int WB        = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int FRAC      = WB - 2;
  localparam int PW        = WB + 3;      // rounded product, signed
  localparam int SW        = PW + 2;      // sum of up to three products
  localparam int SQW       = 2 * WB;      // exact square / sum of squares
  localparam int QW        = FRAC + 1;    // quotient bits of a normalization
  localparam int NUMW      = FRAC + WB;   // dividend of a normalization
  localparam int THR_W     = 30;

  // Register map (word index taken from paddr[2])
  localparam logic REG_THR = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef logic signed [WB-1:0]  word_t;
  typedef logic        [WB-1:0]  mag_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [SW-1:0]  sum_t;
  typedef logic        [SQW-1:0] sq_t;

  localparam word_t WORD_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WB-1){1'b0}}};
  localparam sum_t  SUM_MAX  = {{(SW-WB+1){1'b0}}, {(WB-1){1'b1}}};
  localparam sum_t  SUM_MIN  = {{(SW-WB+1){1'b1}}, {(WB-1){1'b0}}};
  localparam word_t Q_ONE    = {2'b01, {FRAC{1'b0}}};

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
  } prod3_t;

  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
    prod_t p4;
    prod_t p5;
  } prod6_t;

  // Sideband that rides along every stage
  typedef struct packed {
    vec_t d;
    vec_t t1;
    vec_t t2;
    logic deg;
  } side_t;

  function automatic word_t vec_at(vec_t v, int i);
    case (i)
      0:       return v.x;
      1:       return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic mag_t mag_of(word_t v);
    return v[WB-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic sq_t sq_of(word_t v);
    mag_t m;
    m = mag_of(v);
    return sq_t'(m) * sq_t'(m);
  endfunction

  // Magnitude product, round half away from zero, then sign
  function automatic prod_t mulq(word_t a, word_t b);
    sq_t             pr;
    logic [PW-2:0]   r;
    pr = sq_t'(mag_of(a)) * sq_t'(mag_of(b)) + (sq_t'(1) << (FRAC - 1));
    r  = pr[SQW-1:FRAC];
    if (a[WB-1] ^ b[WB-1]) return -$signed({1'b0, r});
    else return $signed({1'b0, r});
  endfunction

  function automatic word_t sat_word(sum_t v);
    if (v > SUM_MAX) return WORD_MAX;
    if (v < SUM_MIN) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic prod6_t cross_prod(vec_t a, vec_t b);
    prod6_t p;
    p.p0 = mulq(a.y, b.z);
    p.p1 = mulq(a.z, b.y);
    p.p2 = mulq(a.z, b.x);
    p.p3 = mulq(a.x, b.z);
    p.p4 = mulq(a.x, b.y);
    p.p5 = mulq(a.y, b.x);
    return p;
  endfunction

  function automatic vec_t cross_fin(prod6_t p);
    vec_t r;
    r.x = sat_word(sum_t'(p.p0) - sum_t'(p.p1));
    r.y = sat_word(sum_t'(p.p2) - sum_t'(p.p3));
    r.z = sat_word(sum_t'(p.p4) - sum_t'(p.p5));
    return r;
  endfunction

  function automatic prod3_t dot_prod(vec_t a, vec_t b);
    prod3_t p;
    p.p0 = mulq(a.x, b.x);
    p.p1 = mulq(a.y, b.y);
    p.p2 = mulq(a.z, b.z);
    return p;
  endfunction

  function automatic word_t dot_fin(prod3_t p);
    return sat_word(sum_t'(p.p0) + sum_t'(p.p1) + sum_t'(p.p2));
  endfunction

  function automatic prod3_t scale_prod(word_t s, vec_t t);
    prod3_t p;
    p.p0 = mulq(s, t.x);
    p.p1 = mulq(s, t.y);
    p.p2 = mulq(s, t.z);
    return p;
  endfunction

  // v - s*t, per component, saturated
  function automatic vec_t sub_fin(vec_t v, prod3_t p);
    vec_t r;
    r.x = sat_word(sum_t'(v.x) - sum_t'(p.p0));
    r.y = sat_word(sum_t'(v.y) - sum_t'(p.p1));
    r.z = sat_word(sum_t'(v.z) - sum_t'(p.p2));
    return r;
  endfunction

  function automatic vec_t comb3(prod3_t a, prod3_t b, prod3_t c);
    vec_t r;
    r.x = sat_word(sum_t'(a.p0) + sum_t'(b.p0) + sum_t'(c.p0));
    r.y = sat_word(sum_t'(a.p1) + sum_t'(b.p1) + sum_t'(c.p1));
    r.z = sat_word(sum_t'(a.p2) + sum_t'(b.p2) + sum_t'(c.p2));
    return r;
  endfunction

endpackage

/* rtl/dpt_norm.sv */
`timescale 1ns / 1ps
// Pipelined vector normalizer: squares, one root bit per stage, one quotient bit per stage.
// Depends on dpt_pkg. One beat per cycle while the global enable is high.
module dpt_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  dpt_pkg::vec_t   in_vec,
  input  dpt_pkg::side_t  in_side,
  output logic            out_vld,
  output dpt_pkg::vec_t   out_vec,
  output dpt_pkg::side_t  out_side
);

  localparam int RT_STEPS = dpt_pkg::WB;
  localparam int DV_STEPS = dpt_pkg::QW;
  localparam int SQX      = dpt_pkg::SQW + 1;
  localparam int REMX     = dpt_pkg::WB + 1;

  typedef logic [SQX-1:0]            ext_t;
  typedef logic [REMX-1:0]           remx_t;
  typedef logic [dpt_pkg::NUMW-1:0]  num_t;
  typedef logic [DV_STEPS-1:0]       quo_t;

  // Squares
  logic              a_vld_r;
  dpt_pkg::vec_t     a_vec_r;
  dpt_pkg::side_t    a_side_r;
  dpt_pkg::sq_t      a_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vec_r   <= in_vec;
      a_side_r  <= in_side;
      a_sq_r[0] <= dpt_pkg::sq_of(in_vec.x);
      a_sq_r[1] <= dpt_pkg::sq_of(in_vec.y);
      a_sq_r[2] <= dpt_pkg::sq_of(in_vec.z);
    end
  end

  // Integer square root, remainder form, one root bit per stage
  logic              rt_vld_r  [0:RT_STEPS];
  dpt_pkg::sq_t      rt_rem_r  [0:RT_STEPS];
  dpt_pkg::mag_t     rt_root_r [0:RT_STEPS];
  dpt_pkg::vec_t     rt_vec_r  [0:RT_STEPS];
  dpt_pkg::side_t    rt_side_r [0:RT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) rt_vld_r[0] <= 1'b0;
    else if (en) rt_vld_r[0] <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem_r[0]  <= a_sq_r[0] + a_sq_r[1] + a_sq_r[2];
      rt_root_r[0] <= '0;
      rt_vec_r[0]  <= a_vec_r;
      rt_side_r[0] <= a_side_r;
    end
  end

  for (genvar j = 0; j < RT_STEPS; j++) begin : g_root
    localparam int B = RT_STEPS - 1 - j;
    ext_t trial;
    logic take;

    // (root + 2^B)^2 - root^2
    assign trial = (ext_t'(rt_root_r[j]) << (B + 1)) + (ext_t'(1) << (2 * B));
    assign take  = ext_t'(rt_rem_r[j]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) rt_vld_r[j+1] <= 1'b0;
      else if (en) rt_vld_r[j+1] <= rt_vld_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem_r[j+1]  <= take ? (rt_rem_r[j] - trial[dpt_pkg::SQW-1:0]) : rt_rem_r[j];
        rt_root_r[j+1] <= take ? (rt_root_r[j] | (dpt_pkg::mag_t'(1) << B)) : rt_root_r[j];
        rt_vec_r[j+1]  <= rt_vec_r[j];
        rt_side_r[j+1] <= rt_side_r[j];
      end
    end
  end

  // Division setup: dividend |c|*2^FRAC + n/2, top bits seed the remainder
  logic              dv_vld_r  [0:DV_STEPS];
  dpt_pkg::mag_t     dv_n_r    [0:DV_STEPS];
  dpt_pkg::side_t    dv_side_r [0:DV_STEPS];
  num_t              dv_num_r  [0:DV_STEPS][3];
  dpt_pkg::mag_t     dv_rem_r  [0:DV_STEPS][3];
  quo_t              dv_q_r    [0:DV_STEPS][3];
  logic              dv_neg_r  [0:DV_STEPS][3];
  num_t              setup_num [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      setup_num[c] = (num_t'(dpt_pkg::mag_of(dpt_pkg::vec_at(rt_vec_r[RT_STEPS], c)))
                      << dpt_pkg::FRAC) + num_t'(rt_root_r[RT_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= rt_vld_r[RT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n_r[0]    <= rt_root_r[RT_STEPS];
      dv_side_r[0] <= rt_side_r[RT_STEPS];
      for (int c = 0; c < 3; c++) begin
        dv_num_r[0][c] <= setup_num[c];
        dv_rem_r[0][c] <= dpt_pkg::mag_t'(setup_num[c][dpt_pkg::NUMW-1:DV_STEPS]);
        dv_q_r[0][c]   <= '0;
        dv_neg_r[0][c] <= dpt_pkg::vec_at(rt_vec_r[RT_STEPS], c) < 0;
      end
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    localparam int B = DV_STEPS - 1 - k;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else if (en) dv_vld_r[k+1] <= dv_vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_n_r[k+1]    <= dv_n_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      remx_t t;
      remx_t diff;
      logic  ge;

      assign t    = {dv_rem_r[k][c], dv_num_r[k][c][B]};
      assign diff = t - remx_t'(dv_n_r[k]);
      assign ge   = t >= remx_t'(dv_n_r[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_num_r[k+1][c] <= dv_num_r[k][c];
          dv_rem_r[k+1][c] <= ge ? diff[dpt_pkg::WB-1:0] : t[dpt_pkg::WB-1:0];
          dv_q_r[k+1][c]   <= ge ? (dv_q_r[k][c] | (quo_t'(1) << B)) : dv_q_r[k][c];
          dv_neg_r[k+1][c] <= dv_neg_r[k][c];
        end
      end
    end
  end

  // Sign and zero-norm handling
  logic              o_vld_r;
  dpt_pkg::vec_t     o_vec_r;
  dpt_pkg::side_t    o_side_r;
  dpt_pkg::word_t    fin [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dv_n_r[DV_STEPS] == '0) fin[c] = '0;
      else if (dv_neg_r[DV_STEPS][c]) fin[c] = -dpt_pkg::word_t'({1'b0, dv_q_r[DV_STEPS][c]});
      else fin[c] = dpt_pkg::word_t'({1'b0, dv_q_r[DV_STEPS][c]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= dv_vld_r[DV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_vec_r.x <= fin[0];
      o_vec_r.y <= fin[1];
      o_vec_r.z <= fin[2];
      o_side_r  <= dv_side_r[DV_STEPS];
    end
  end

  assign out_vld  = o_vld_r;
  assign out_vec  = o_vec_r;
  assign out_side = o_side_r;

endmodule

/* rtl/director_parallel_transport_unit.sv */
`timescale 1ns / 1ps
// Top level: director parallel transport pipeline with a threshold register.
// Depends on dpt_pkg and dpt_norm.
//
// Takes one beat per cycle and gives one result beat per input beat, in order. A beat
// passes through four normalizations (a 32-stage square root followed by a 31-stage
// divider, one bit per stage each) and multiply and sum stages. The whole pipeline
// advances together; it halts only while a finished result sits in the output register
// and out_stall is high, and in_stall shows exactly that. Near-parallel tangents
// (rounded squared binormal length below the threshold register, or a zero binormal)
// return the director bits unchanged with out_passed_through set. The threshold lives
// at byte address 0 and should be written while no beat is in flight.
module director_parallel_transport_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  dpt_pkg::word_t     in_dir_x,
  input  dpt_pkg::word_t     in_dir_y,
  input  dpt_pkg::word_t     in_dir_z,
  input  dpt_pkg::word_t     in_from_tan_x,
  input  dpt_pkg::word_t     in_from_tan_y,
  input  dpt_pkg::word_t     in_from_tan_z,
  input  dpt_pkg::word_t     in_to_tan_x,
  input  dpt_pkg::word_t     in_to_tan_y,
  input  dpt_pkg::word_t     in_to_tan_z,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output dpt_pkg::word_t     out_x,
  output dpt_pkg::word_t     out_y,
  output dpt_pkg::word_t     out_z,
  output logic               out_passed_through,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SQX = dpt_pkg::SQW + 1;
  typedef logic [SQX-1:0] ext_t;

  logic en;

  // Threshold register
  logic [dpt_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= dpt_pkg::THR_RESET;
    else if (psel && penable && pwrite && (paddr[2] == dpt_pkg::REG_THR))
      thr_r <= pwdata[dpt_pkg::THR_W-1:0];
  end

  assign prdata = (paddr[2] == dpt_pkg::REG_THR) ? 32'(thr_r) : '0;
  assign pready = 1'b1;

  // Global advance: stop only when the output beat is held
  logic out_vld_r;
  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  dpt_pkg::side_t in_side;
  assign in_side.d.x  = in_dir_x;
  assign in_side.d.y  = in_dir_y;
  assign in_side.d.z  = in_dir_z;
  assign in_side.t1.x = in_from_tan_x;
  assign in_side.t1.y = in_from_tan_y;
  assign in_side.t1.z = in_from_tan_z;
  assign in_side.t2.x = in_to_tan_x;
  assign in_side.t2.y = in_to_tan_y;
  assign in_side.t2.z = in_to_tan_z;
  assign in_side.deg  = 1'b0;

  // Binormal cross products
  logic             c1_vld_r;
  dpt_pkg::prod6_t  c1_cp_r;
  dpt_pkg::side_t   c1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_vld_r <= 1'b0;
    else if (en) c1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_cp_r   <= dpt_pkg::cross_prod(in_side.t1, in_side.t2);
      c1_side_r <= in_side;
    end
  end

  logic             c2_vld_r;
  dpt_pkg::vec_t    c2_b_r;
  dpt_pkg::side_t   c2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_vld_r <= 1'b0;
    else if (en) c2_vld_r <= c1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_b_r    <= dpt_pkg::cross_fin(c1_cp_r);
      c2_side_r <= c1_side_r;
    end
  end

  // Squared length for the parallel-tangent test
  logic             c3_vld_r;
  dpt_pkg::vec_t    c3_b_r;
  dpt_pkg::side_t   c3_side_r;
  dpt_pkg::sq_t     c3_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c3_vld_r <= 1'b0;
    else if (en) c3_vld_r <= c2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_b_r    <= c2_b_r;
      c3_side_r <= c2_side_r;
      c3_sq_r[0] <= dpt_pkg::sq_of(c2_b_r.x);
      c3_sq_r[1] <= dpt_pkg::sq_of(c2_b_r.y);
      c3_sq_r[2] <= dpt_pkg::sq_of(c2_b_r.z);
    end
  end

  ext_t bsq;
  logic deg_nxt;
  assign bsq = (ext_t'(c3_sq_r[0]) + ext_t'(c3_sq_r[1]) + ext_t'(c3_sq_r[2])
                + (ext_t'(1) << (dpt_pkg::FRAC - 1))) >> dpt_pkg::FRAC;
  assign deg_nxt = (bsq < ext_t'(thr_r)) || (c3_b_r == '0);

  // Sideband with the parallel flag filled in
  dpt_pkg::side_t   c4_side_nxt;

  always_comb begin
    c4_side_nxt     = c3_side_r;
    c4_side_nxt.deg = deg_nxt;
  end

  logic             c4_vld_r;
  dpt_pkg::vec_t    c4_b_r;
  dpt_pkg::side_t   c4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c4_vld_r <= 1'b0;
    else if (en) c4_vld_r <= c3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_b_r    <= c3_b_r;
      c4_side_r <= c4_side_nxt;
    end
  end

  // Normalizer and projection hookup
  logic             nin_vld  [4];
  dpt_pkg::vec_t    nin_vec  [4];
  dpt_pkg::side_t   nin_side [4];
  logic             nout_vld [4];
  dpt_pkg::vec_t    nout_vec [4];
  dpt_pkg::side_t   nout_side[4];
  logic             pin_vld  [3];
  dpt_pkg::vec_t    pin_vec  [3];
  dpt_pkg::side_t   pin_side [3];

  assign nin_vld[0]  = c4_vld_r;
  assign nin_vec[0]  = c4_b_r;
  assign nin_side[0] = c4_side_r;
  assign pin_vld[0]  = nout_vld[0];
  assign pin_vec[0]  = nout_vec[0];
  assign pin_side[0] = nout_side[0];
  assign pin_vld[1]  = nout_vld[1];
  assign pin_vec[1]  = nout_vec[1];
  assign pin_side[1] = nout_side[1];

  for (genvar i = 0; i < 4; i++) begin : g_norm
    dpt_norm u_norm (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (nin_vld[i]),
      .in_vec   (nin_vec[i]),
      .in_side  (nin_side[i]),
      .out_vld  (nout_vld[i]),
      .out_vec  (nout_vec[i]),
      .out_side (nout_side[i])
    );
  end

  // Remove the component along a tangent: first against t1, then against t2 twice
  for (genvar p = 0; p < 3; p++) begin : g_proj
    localparam bit USE_T1 = (p == 0);

    logic             q1_vld_r, q2_vld_r, q3_vld_r, q4_vld_r;
    dpt_pkg::prod3_t  q1_dp_r, q3_sp_r;
    dpt_pkg::word_t   q2_s_r;
    dpt_pkg::vec_t    q1_v_r, q2_v_r, q3_v_r, q4_v_r;
    dpt_pkg::side_t   q1_side_r, q2_side_r, q3_side_r, q4_side_r;
    dpt_pkg::vec_t    tan_in, tan_q2;

    assign tan_in = USE_T1 ? pin_side[p].t1 : pin_side[p].t2;
    assign tan_q2 = USE_T1 ? q2_side_r.t1 : q2_side_r.t2;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q1_vld_r <= 1'b0;
        q2_vld_r <= 1'b0;
        q3_vld_r <= 1'b0;
        q4_vld_r <= 1'b0;
      end else if (en) begin
        q1_vld_r <= pin_vld[p];
        q2_vld_r <= q1_vld_r;
        q3_vld_r <= q2_vld_r;
        q4_vld_r <= q3_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q1_dp_r   <= dpt_pkg::dot_prod(pin_vec[p], tan_in);
        q1_v_r    <= pin_vec[p];
        q1_side_r <= pin_side[p];
        q2_s_r    <= dpt_pkg::dot_fin(q1_dp_r);
        q2_v_r    <= q1_v_r;
        q2_side_r <= q1_side_r;
        q3_sp_r   <= dpt_pkg::scale_prod(q2_s_r, tan_q2);
        q3_v_r    <= q2_v_r;
        q3_side_r <= q2_side_r;
        q4_v_r    <= dpt_pkg::sub_fin(q3_v_r, q3_sp_r);
        q4_side_r <= q3_side_r;
      end
    end

    assign nin_vld[p+1]  = q4_vld_r;
    assign nin_vec[p+1]  = q4_v_r;
    assign nin_side[p+1] = q4_side_r;
  end

  // Normals and director coordinates
  logic             f1_vld_r, f2_vld_r, f3_vld_r, f4_vld_r, f5_vld_r, f6_vld_r;
  dpt_pkg::prod6_t  f1_cpa_r, f1_cpb_r;
  dpt_pkg::prod3_t  f1_dp_r;
  dpt_pkg::vec_t    f1_b_r, f2_b_r, f3_b_r, f4_b_r;
  dpt_pkg::side_t   f1_side_r, f2_side_r, f3_side_r, f4_side_r, f5_side_r, f6_side_r;
  dpt_pkg::vec_t    f2_n1_r, f2_n2_r, f3_n2_r, f4_n2_r;
  dpt_pkg::word_t   f2_s1_r, f3_s1_r, f4_s1_r, f4_s2_r, f4_s3_r;
  dpt_pkg::prod3_t  f3_dpn_r, f3_dpb_r;
  dpt_pkg::prod3_t  f5_pa_r, f5_pb_r, f5_pc_r;
  dpt_pkg::vec_t    f6_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
      f5_vld_r <= 1'b0;
      f6_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= nout_vld[2];
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
      f5_vld_r <= f4_vld_r;
      f6_vld_r <= f5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // n1 = t1 x b, n2 = t2 x b, s1 = d.t1
      f1_cpa_r  <= dpt_pkg::cross_prod(nout_side[2].t1, nout_vec[2]);
      f1_cpb_r  <= dpt_pkg::cross_prod(nout_side[2].t2, nout_vec[2]);
      f1_dp_r   <= dpt_pkg::dot_prod(nout_side[2].d, nout_side[2].t1);
      f1_b_r    <= nout_vec[2];
      f1_side_r <= nout_side[2];

      f2_n1_r   <= dpt_pkg::cross_fin(f1_cpa_r);
      f2_n2_r   <= dpt_pkg::cross_fin(f1_cpb_r);
      f2_s1_r   <= dpt_pkg::dot_fin(f1_dp_r);
      f2_b_r    <= f1_b_r;
      f2_side_r <= f1_side_r;

      // s2 = d.n1, s3 = d.b
      f3_dpn_r  <= dpt_pkg::dot_prod(f2_side_r.d, f2_n1_r);
      f3_dpb_r  <= dpt_pkg::dot_prod(f2_side_r.d, f2_b_r);
      f3_n2_r   <= f2_n2_r;
      f3_s1_r   <= f2_s1_r;
      f3_b_r    <= f2_b_r;
      f3_side_r <= f2_side_r;

      f4_s2_r   <= dpt_pkg::dot_fin(f3_dpn_r);
      f4_s3_r   <= dpt_pkg::dot_fin(f3_dpb_r);
      f4_s1_r   <= f3_s1_r;
      f4_n2_r   <= f3_n2_r;
      f4_b_r    <= f3_b_r;
      f4_side_r <= f3_side_r;

      // r = s1 t2 + s2 n2 + s3 b
      f5_pa_r   <= dpt_pkg::scale_prod(f4_s1_r, f4_side_r.t2);
      f5_pb_r   <= dpt_pkg::scale_prod(f4_s2_r, f4_n2_r);
      f5_pc_r   <= dpt_pkg::scale_prod(f4_s3_r, f4_b_r);
      f5_side_r <= f4_side_r;

      f6_r_r    <= dpt_pkg::comb3(f5_pa_r, f5_pb_r, f5_pc_r);
      f6_side_r <= f5_side_r;
    end
  end

  assign pin_vld[2]  = f6_vld_r;
  assign pin_vec[2]  = f6_r_r;
  assign pin_side[2] = f6_side_r;

  // Output register, pass-through select
  dpt_pkg::vec_t  out_vec_r;
  logic           out_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= nout_vld[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec_r <= nout_side[3].deg ? nout_side[3].d : nout_vec[3];
      out_pt_r  <= nout_side[3].deg;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_x              = out_vec_r.x;
  assign out_y              = out_vec_r.y;
  assign out_z              = out_vec_r.z;
  assign out_passed_through = out_pt_r;

  // Input is held off only while a result waits on a stalled output
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output beat");

  // A transported director is unit length, so no component exceeds one
  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_passed_through) |->
      (out_x <= dpt_pkg::Q_ONE && out_x >= -dpt_pkg::Q_ONE &&
       out_y <= dpt_pkg::Q_ONE && out_y >= -dpt_pkg::Q_ONE &&
       out_z <= dpt_pkg::Q_ONE && out_z >= -dpt_pkg::Q_ONE))
    else $error("normalized component out of range");

  // Reset empties the output stage
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* tb/sv/tb_director_parallel_transport_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for director_parallel_transport_unit: random and directed transports
// checked beat by beat against an in-bench fixed-point predictor. Depends on dpt_pkg and the RTL.
module tb_director_parallel_transport_unit;

  localparam int LATENCY   = 291;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 800;
  localparam logic [2:0] ADDR_THR = 3'd0;

  typedef struct {
    dpt_pkg::word_t d[3];
    dpt_pkg::word_t t1[3];
    dpt_pkg::word_t t2[3];
  } xport_t;

  typedef struct {
    dpt_pkg::word_t v[3];
    logic  pass;
  } dir_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dpt_pkg::word_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  dpt_pkg::word_t in_from_tan_x = '0, in_from_tan_y = '0, in_from_tan_z = '0;
  dpt_pkg::word_t in_to_tan_x = '0, in_to_tan_y = '0, in_to_tan_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dpt_pkg::word_t out_x, out_y, out_z;
  logic out_passed_through;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  director_parallel_transport_unit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and bookkeeping
  logic [29:0] thr_model = 30'd16;
  xport_t   pending_beats[$];
  dir_res_t expected_dirs[$];
  int errors = 0, n_checked = 0, n_passed = 0, idle_cycles = 0;
  bit sender_hold = 1'b0, long_req = 1'b0;

  // ---------------- fixed-point predictor ----------------
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint unsigned RHALF = 64'd1 << (dpt_pkg::FRAC - 1);

  function automatic longint clampq(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint unsigned absq(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned r;
    r = (absq(a) * absq(b) + RHALF) >> dpt_pkg::FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else r >>= 1;
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned len_sq(longint v[3]);
    return absq(v[0])*absq(v[0]) + absq(v[1])*absq(v[1]) + absq(v[2])*absq(v[2]);
  endfunction

  function automatic void crossq(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = clampq(qmul(a[1], b[2]) - qmul(a[2], b[1]));
    r[1] = clampq(qmul(a[2], b[0]) - qmul(a[0], b[2]));
    r[2] = clampq(qmul(a[0], b[1]) - qmul(a[1], b[0]));
  endfunction

  function automatic longint dotq(longint a[3], longint b[3]);
    return clampq(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
  endfunction

  // v -= s*t, saturating
  function automatic void reject(inout longint v[3], input longint s, input longint t[3]);
    for (int i = 0; i < 3; i++) v[i] = clampq(v[i] - qmul(s, t[i]));
  endfunction

  function automatic void unitize(inout longint v[3]);
    longint unsigned n, q;
    n = root_floor(len_sq(v));
    for (int i = 0; i < 3; i++) begin
      if (n == 0) v[i] = 0;
      else begin
        q = ((absq(v[i]) << dpt_pkg::FRAC) + n / 2) / n;
        v[i] = clampq(v[i] < 0 ? -longint'(q) : longint'(q));
      end
    end
  endfunction

  function automatic dir_res_t transport_dir(xport_t it);
    dir_res_t res;
    longint d[3], t1[3], t2[3], b[3], n1[3], n2[3], r[3];
    longint s1, s2, s3;
    longint unsigned bsq;
    for (int i = 0; i < 3; i++) begin
      d[i] = it.d[i];
      t1[i] = it.t1[i];
      t2[i] = it.t2[i];
    end
    crossq(t1, t2, b);
    bsq = (len_sq(b) + RHALF) >> dpt_pkg::FRAC;
    // near-parallel tangents: director handed back untouched
    if (bsq < thr_model || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      res.v = it.d;
      res.pass = 1'b1;
      return res;
    end
    unitize(b);
    reject(b, dotq(b, t1), t1);
    unitize(b);
    reject(b, dotq(b, t2), t2);
    unitize(b);
    crossq(t1, b, n1);
    crossq(t2, b, n2);
    s1 = dotq(d, t1);
    s2 = dotq(d, n1);
    s3 = dotq(d, b);
    for (int i = 0; i < 3; i++)
      r[i] = clampq(qmul(s1, t2[i]) + qmul(s2, n2[i]) + qmul(s3, b[i]));
    reject(r, dotq(r, t2), t2);
    unitize(r);
    for (int i = 0; i < 3; i++) res.v[i] = dpt_pkg::word_t'(r[i]);
    res.pass = 1'b0;
    return res;
  endfunction

  // ---------------- driver ----------------
  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int draw_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_dirs.insert(expected_dirs.size(), transport_dir(pending_beats.pop_front()));
      // slot is free: count down a gap or offer the next beat
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 && !sender_hold) begin
          in_valid      <= 1'b1;
          in_dir_x      <= pending_beats[0].d[0];
          in_dir_y      <= pending_beats[0].d[1];
          in_dir_z      <= pending_beats[0].d[2];
          in_from_tan_x <= pending_beats[0].t1[0];
          in_from_tan_y <= pending_beats[0].t1[1];
          in_from_tan_z <= pending_beats[0].t1[2];
          in_to_tan_x   <= pending_beats[0].t2[0];
          in_to_tan_y   <= pending_beats[0].t2[1];
          in_to_tan_z   <= pending_beats[0].t2[2];
          gap_left      <= draw_gap();
        end else in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d expected %0d", n_checked, what, got, want);
  endtask

  int stall_left = 0;
  int long_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_dirs.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          dir_res_t e;
          e = expected_dirs.pop_front();
          if (out_x != e.v[0]) report_mismatch("out_x", out_x, e.v[0]);
          if (out_y != e.v[1]) report_mismatch("out_y", out_y, e.v[1]);
          if (out_z != e.v[2]) report_mismatch("out_z", out_z, e.v[2]);
          if (out_passed_through != e.pass)
            report_mismatch("passed_through", out_passed_through, e.pass);
          n_passed += e.pass;
        end
        n_checked++;
      end
      // receiver back-pressure, long hold-off counted here
      if (long_req) begin
        long_req = 1'b0;
        long_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (long_left > 0) begin
        long_left <= long_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)
        || !rst_n || (pending_beats.size() == 0 && expected_dirs.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("director_parallel_transport_unit regression: fail");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic dpt_pkg::word_t rand_word();
    case ($urandom_range(0, 6))
      0: return dpt_pkg::WORD_MAX;
      1: return dpt_pkg::WORD_MIN;
      2: return dpt_pkg::Q_ONE;
      3: return -dpt_pkg::Q_ONE;
      4: return dpt_pkg::word_t'($urandom_range(0, 64)) - 32;
      default: return dpt_pkg::word_t'($urandom);
    endcase
  endfunction

  // roughly unit tangent with random direction, built near Q1.30 one
  function automatic void rand_unit(output dpt_pkg::word_t t[3]);
    longint v[3];
    for (int i = 0; i < 3; i++) v[i] = longint'($signed($urandom)) >>> 1;
    unitize(v);
    for (int i = 0; i < 3; i++) t[i] = dpt_pkg::word_t'(v[i]);
  endfunction

  task automatic queue_beat(dpt_pkg::word_t d[3], dpt_pkg::word_t t1[3],
                            dpt_pkg::word_t t2[3]);
    xport_t it;
    it.d = d;
    it.t1 = t1;
    it.t2 = t2;
    pending_beats.insert(pending_beats.size(), it);
  endtask

  task automatic add_random(int n);
    dpt_pkg::word_t d[3], t1[3], t2[3];
    for (int k = 0; k < n; k++) begin
      rand_unit(d);
      rand_unit(t1);
      case ($urandom_range(0, 9))
        0: t2 = t1;                                   // parallel
        1: for (int i = 0; i < 3; i++) t2[i] = -t1[i]; // antiparallel
        2: for (int i = 0; i < 3; i++)                 // nearly parallel
             t2[i] = t1[i] + dpt_pkg::word_t'($urandom_range(0, 8000)) - 4000;
        3: for (int i = 0; i < 3; i++) begin           // raw noise everywhere
             d[i] = rand_word();
             t1[i] = rand_word();
             t2[i] = rand_word();
           end
        default: rand_unit(t2);
      endcase
      queue_beat(d, t1, t2);
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_dirs.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_THR; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_model = val[29:0];
  endtask

  initial begin
    dpt_pkg::word_t d[3], t1[3], t2[3], ex[3], ey[3], ez[3];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axes, parallel, antiparallel, zero, extremes
    ex = '{dpt_pkg::Q_ONE, 0, 0}; ey = '{0, dpt_pkg::Q_ONE, 0}; ez = '{0, 0, dpt_pkg::Q_ONE};
    queue_beat(ez, ex, ey);
    queue_beat(ex, ex, ey);
    queue_beat(ey, ex, ex);
    queue_beat(ey, ex, '{-dpt_pkg::Q_ONE, 0, 0});
    queue_beat('{dpt_pkg::WORD_MAX, dpt_pkg::WORD_MIN, 0}, ex, ex);
    queue_beat('{0, 0, 0}, ex, ey);
    queue_beat(ez, '{0, 0, 0}, ey);
    queue_beat('{dpt_pkg::WORD_MAX, dpt_pkg::WORD_MAX, dpt_pkg::WORD_MAX},
               '{dpt_pkg::WORD_MAX, dpt_pkg::WORD_MIN, dpt_pkg::WORD_MAX},
               '{dpt_pkg::WORD_MIN, dpt_pkg::WORD_MAX, dpt_pkg::WORD_MIN});
    queue_beat('{dpt_pkg::WORD_MIN, dpt_pkg::WORD_MIN, dpt_pkg::WORD_MIN},
               '{dpt_pkg::WORD_MIN, dpt_pkg::WORD_MIN, dpt_pkg::WORD_MIN},
               '{dpt_pkg::WORD_MIN, dpt_pkg::WORD_MAX, dpt_pkg::WORD_MAX});
    queue_beat('{-1, -1, -1}, '{-1, 1, -1}, '{1, -1, 1});
    queue_beat(ex, ey, '{0, dpt_pkg::Q_ONE, 3});
    queue_beat(ex, ey, ez);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        d[i] = rand_word(); t1[i] = rand_word(); t2[i] = rand_word();
      end
      queue_beat(d, t1, t2);
    end
    wait_drained();

    // reset threshold, then sweep settings including both extremes
    add_random(700);
    wait_drained();
    write_threshold(32'd0);
    add_random(300);
    wait_drained();
    write_threshold(32'h3fff_ffff);
    add_random(150);
    wait_drained();
    write_threshold(32'h0010_0000);
    add_random(300);
    // receiver holds off long while sender keeps offering
    repeat (50) @(posedge clk);
    long_req = 1'b1;
    @(posedge clk);
    while (long_req || long_left > 0) @(posedge clk);
    // sender pauses until everything is back
    sender_hold = 1'b1;
    while (expected_dirs.size() != 0 || pending_beats.size() != 0 && in_valid) @(posedge clk);
    sender_hold = 1'b0;
    wait_drained();
    write_threshold(32'd16);
    add_random(350);
    wait_drained();

    $display("Checked %0d transport beats (%0d passed through) over five threshold settings,",
             n_checked, n_passed);
    $display("with random gaps, back-pressure and a full-pipeline hold-off.");
    if (errors == 0) $display("director_parallel_transport_unit regression: pass");
    else $display("director_parallel_transport_unit regression: fail");
    $finish;
  end

endmodule
